/* sv/z80ie_pkg.sv */
`default_nettype none
package z80ie_pkg;

    localparam int unsigned MaxBytes = 8;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_PATTERN = 3'd1,
        ERR_OPERAND = 3'd2,
        ERR_RANGE   = 3'd3,
        ERR_IMODE   = 3'd4,
        ERR_MNEM    = 3'd5
    } t_err;

    // Register codes
    localparam logic [4:0] RegA   = 5'd1;
    localparam logic [4:0] RegIxh = 5'd8;
    localparam logic [4:0] RegIxl = 5'd9;
    localparam logic [4:0] RegIyh = 5'd10;
    localparam logic [4:0] RegIyl = 5'd11;
    localparam logic [4:0] RegAf  = 5'd12;
    localparam logic [4:0] RegAfx = 5'd13;
    localparam logic [4:0] RegBc  = 5'd14;
    localparam logic [4:0] RegDe  = 5'd15;
    localparam logic [4:0] RegHl  = 5'd16;
    localparam logic [4:0] RegIx  = 5'd17;
    localparam logic [4:0] RegIy  = 5'd18;
    localparam logic [4:0] RegSp  = 5'd19;

    // Commands
    localparam logic [5:0] CmdLastImplied = 6'd21;
    localparam logic [5:0] CmdFirstEd     = 6'd9;
    localparam logic [5:0] CmdIm   = 6'd22;
    localparam logic [5:0] CmdPush = 6'd23;
    localparam logic [5:0] CmdPop  = 6'd24;
    localparam logic [5:0] CmdEx   = 6'd25;
    localparam logic [5:0] CmdAnd  = 6'd26;
    localparam logic [5:0] CmdCp   = 6'd29;
    localparam logic [5:0] CmdAdd  = 6'd30;
    localparam logic [5:0] CmdAdc  = 6'd31;
    localparam logic [5:0] CmdNone = 6'd33;

    // Operand forms
    localparam logic [3:0] FormNone   = 4'd0;
    localparam logic [3:0] FormReg    = 4'd1;
    localparam logic [3:0] FormImm    = 4'd2;
    localparam logic [3:0] FormInd    = 4'd3;
    localparam logic [3:0] FormIdxP   = 4'd4;
    localparam logic [3:0] FormIdxM   = 4'd5;
    localparam logic [3:0] FormRegReg = 4'd6;
    localparam logic [3:0] FormRegImm = 4'd7;
    localparam logic [3:0] FormIndReg = 4'd8;

    // Classified instruction handed from front to back
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [3:0]               count;   // 0..8 (0 only for no-instruction words); error words carry 1
        t_err                     err;
    } t_instr;

    function automatic logic [7:0] implied_code(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0:  c = 8'h00; 5'd1:  c = 8'hF3; 5'd2:  c = 8'hFB; 5'd3:  c = 8'h76;
            5'd4:  c = 8'hD9; 5'd5:  c = 8'h27; 5'd6:  c = 8'h2F; 5'd7:  c = 8'h3F;
            5'd8:  c = 8'h37; 5'd9:  c = 8'h44; 5'd10: c = 8'hA0; 5'd11: c = 8'hB0;
            5'd12: c = 8'hA8; 5'd13: c = 8'hB8; 5'd14: c = 8'hA1; 5'd15: c = 8'hB1;
            5'd16: c = 8'hA9; 5'd17: c = 8'hB9; 5'd18: c = 8'hA3; 5'd19: c = 8'hB3;
            5'd20: c = 8'hAB; 5'd21: c = 8'hBB;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] alu_code(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'hA0; 3'd1: c = 8'hB0; 3'd2: c = 8'hA8;
            3'd3: c = 8'hB8; 3'd4: c = 8'h80; 3'd5: c = 8'h88;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* sv/z80ie_front.sv */
`default_nettype none
// Classifies one instruction word into its byte list or an error.
module z80ie_front
    import z80ie_pkg::*;
(
    input  wire logic [5:0]  i_command,
    input  wire logic [3:0]  i_operand_form,
    input  wire logic [4:0]  i_first_register,
    input  wire logic [4:0]  i_second_register,
    input  wire logic [16:0] i_immediate_value,
    output t_instr           o_instr
);

    logic [MaxBytes-1:0][7:0] b;
    logic [3:0] n;
    t_err       e;

    always_comb begin
        logic [7:0]  code;
        logic [7:0]  c16;
        logic [7:0]  sel;
        logic [7:0]  base;
        logic [7:0]  disp;
        logic [4:0]  ar;
        logic [3:0]  af;
        logic        neg;
        logic        in8;
        logic        ok16;
        logic        carry;
        logic        do8;
        logic        do16;
        logic [4:0]  r1;
        logic [4:0]  r2;
        logic [16:0] v;
        r1 = i_first_register;
        r2 = i_second_register;
        v  = i_immediate_value;
        b = '0;
        n = 4'd0;
        e = ERR_NONE;
        neg  = v[16];
        // -128..255
        in8  = neg ? (v[15:7] == 9'h1FF) : (v[15:8] == 8'h00);
        ok16 = !neg || v[15];
        carry = (i_command == CmdAdc);
        code = alu_code(3'(i_command - CmdAnd));
        c16  = carry ? 8'h4A : 8'h09;
        base = (i_command == CmdPush) ? 8'hC5 : 8'hC1;
        do8 = 1'b0;
        do16 = 1'b0;
        ar = r1;
        af = i_operand_form;
        sel = 8'h00;
        disp = 8'h00;

        if (i_command <= CmdLastImplied) begin
            if (i_operand_form != FormNone) e = ERR_PATTERN;
            else if (i_command >= CmdFirstEd) begin
                b[0] = 8'hED; b[1] = implied_code(i_command[4:0]); n = 4'd2;
            end else begin
                b[0] = implied_code(i_command[4:0]); n = 4'd1;
            end
        end else if (i_command == CmdIm) begin
            if (i_operand_form != FormImm) e = ERR_PATTERN;
            else if (neg || v[15:0] > 16'd2) e = ERR_IMODE;
            else begin
                b[0] = 8'hED;
                b[1] = (v[1:0] == 2'd0) ? 8'h46 : (v[1:0] == 2'd1) ? 8'h56 : 8'h5E;
                n = 4'd2;
            end
        end else if (i_command == CmdPush || i_command == CmdPop) begin
            if (i_operand_form != FormReg) e = ERR_PATTERN;
            else if (r1 == RegBc) begin b[0] = base; n = 4'd1; end
            else if (r1 == RegDe) begin b[0] = base | 8'h10; n = 4'd1; end
            else if (r1 == RegHl) begin b[0] = base | 8'h20; n = 4'd1; end
            else if (r1 == RegAf) begin b[0] = base | 8'h30; n = 4'd1; end
            else if (r1 == RegIx || r1 == RegIy) begin
                b[0] = (r1 == RegIx) ? 8'hDD : 8'hFD; b[1] = base | 8'h20; n = 4'd2;
            end else e = ERR_OPERAND;
        end else if (i_command == CmdEx) begin
            if (i_operand_form == FormRegReg) begin
                if (r1 == RegDe && r2 == RegHl) begin b[0] = 8'hEB; n = 4'd1; end
                else if (r1 == RegAf && r2 == RegAfx) begin b[0] = 8'h08; n = 4'd1; end
                else e = ERR_OPERAND;
            end else if (i_operand_form == FormIndReg) begin
                if (r1 != RegSp) e = ERR_OPERAND;
                else if (r2 == RegIx || r2 == RegIy) begin
                    b[0] = (r2 == RegIx) ? 8'hDD : 8'hFD; b[1] = 8'hE3; n = 4'd2;
                end else if (r2 == RegHl) begin b[0] = 8'hE3; n = 4'd1; end
                else e = ERR_OPERAND;
            end else e = ERR_PATTERN;
        end else if (i_command >= CmdAnd && i_command <= CmdCp) begin
            do8 = 1'b1;
        end else if (i_command == CmdAdd || i_command == CmdAdc) begin
            if (i_operand_form >= FormReg && i_operand_form <= FormIdxM) do8 = 1'b1;
            else if (i_operand_form == FormRegReg || i_operand_form == FormRegImm) begin
                if (r1 == RegA) begin
                    do8 = 1'b1; ar = r2;
                    af = (i_operand_form == FormRegReg) ? FormReg : FormImm;
                end else if (r1 == RegAf || (r1 >= RegBc && r1 <= RegSp)) do16 = 1'b1;
                else e = ERR_OPERAND;
            end else e = ERR_PATTERN;
        end else if (i_command != CmdNone) begin
            e = ERR_MNEM;
        end

        if (do8) begin
            if (af == FormReg) begin
                if (ar == RegA) begin b[0] = code | 8'h07; n = 4'd1; end
                else if (ar >= 5'd2 && ar <= 5'd7) begin
                    b[0] = code | {5'd0, 3'(ar - 5'd2)}; n = 4'd1;
                end else if (ar >= RegIxh && ar <= RegIyl) begin
                    b[0] = (ar <= RegIxl) ? 8'hDD : 8'hFD;
                    b[1] = code | ((ar == RegIxh || ar == RegIyh) ? 8'h04 : 8'h05);
                    n = 4'd2;
                end else e = ERR_OPERAND;
            end else if (af == FormImm) begin
                if (!in8) e = ERR_RANGE;
                else begin b[0] = code | 8'h46; b[1] = v[7:0]; n = 4'd2; end
            end else if (af == FormInd) begin
                if (ar == RegHl) begin b[0] = code | 8'h06; n = 4'd1; end
                else if (ar == RegIx || ar == RegIy) begin
                    b[0] = (ar == RegIx) ? 8'hDD : 8'hFD; b[1] = code | 8'h06;
                    b[2] = 8'h00; n = 4'd3;
                end else e = ERR_OPERAND;
            end else if (af == FormIdxP || af == FormIdxM) begin
                disp = (af == FormIdxP) ? v[7:0] : 8'(8'd0 - v[7:0]);
                if (ar != RegIx && ar != RegIy) e = ERR_OPERAND;
                else if (neg || v[15:0] > ((af == FormIdxP) ? 16'd127 : 16'd128))
                    e = ERR_RANGE;
                else begin
                    b[0] = (ar == RegIx) ? 8'hDD : 8'hFD; b[1] = code | 8'h06;
                    b[2] = disp; n = 4'd3;
                end
            end else e = ERR_PATTERN;
        end

        if (do16) begin
            if (i_operand_form == FormRegReg) begin
                if (r2 == RegBc) sel = 8'h00;
                else if (r2 == RegDe) sel = 8'h10;
                else if (r2 == r1) sel = 8'h20;
                else sel = 8'h30;
                if (r1 != RegHl && (carry || (r1 != RegIx && r1 != RegIy))) e = ERR_OPERAND;
                else if (r2 != RegBc && r2 != RegDe && r2 != r1 && r2 != RegSp)
                    e = ERR_OPERAND;
                else if (carry) begin
                    b[0] = 8'hED; b[1] = c16 | sel; n = 4'd2;
                end else if (r1 == RegHl) begin
                    b[0] = c16 | sel; n = 4'd1;
                end else begin
                    b[0] = (r1 == RegIx) ? 8'hDD : 8'hFD; b[1] = c16 | sel; n = 4'd2;
                end
            end else begin
                if (carry) e = ERR_OPERAND;
                else if (r1 != RegHl && r1 != RegIx && r1 != RegIy) e = ERR_OPERAND;
                else if (!ok16) e = ERR_RANGE;
                else begin
                    b[0] = 8'hD5; b[1] = 8'h16; b[2] = v[15:8];
                    b[3] = 8'h1E; b[4] = v[7:0];
                    if (r1 == RegHl) begin
                        b[5] = c16 | 8'h10; b[6] = 8'hD1; n = 4'd7;
                    end else begin
                        b[5] = (r1 == RegIx) ? 8'hDD : 8'hFD;
                        b[6] = c16 | 8'h10; b[7] = 8'hD1; n = 4'd8;
                    end
                end
            end
        end

        if (e != ERR_NONE) begin
            b = '0;
            n = 4'd1;
        end
    end

    assign o_instr.bytes = b;
    assign o_instr.count = n;
    assign o_instr.err   = e;

endmodule
`default_nettype wire

/* sv/z80ie_queue.sv */
`default_nettype none
// Two-entry queue between front and back.
module z80ie_queue
    import z80ie_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr,
    input  wire t_instr i_data,
    output logic        o_full,
    input  wire logic   i_rd,
    output logic        o_empty,
    output t_instr      o_data
);

    t_instr     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (i_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = r_cnt[1];
    assign o_empty = (r_cnt == 2'd0);

endmodule
`default_nettype wire

/* sv/z80ie_back.sv */
`default_nettype none
// Steps through one queued instruction, one byte a cycle while the output is free or popped, into the output register.
module z80ie_back
    import z80ie_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_empty,
    input  wire t_instr i_q_data,
    output logic        o_q_rd,
    output logic        o_empty,
    input  wire logic   i_pop,
    output logic [7:0]  o_code_byte,
    output logic [15:0] o_byte_address,
    output logic        o_last_of_run,
    output logic [2:0]  o_error_code
);

    logic [2:0]  r_idx, n_idx;
    logic [15:0] r_pc, n_pc;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic [15:0] r_addr;
    logic        r_last;
    t_err        r_err;
    logic        load, last;

    // Load when the output register is free this cycle and the queue holds an entry
    assign load = !i_q_empty && (!r_valid || i_pop);
    assign last = ({1'b0, r_idx} == 4'(i_q_data.count - 4'd1));
    assign o_q_rd = load && last;

    always_comb begin
        n_idx = r_idx;
        n_pc  = r_pc;
        if (load) begin
            n_idx = last ? 3'd0 : 3'(r_idx + 3'd1);
            if (i_q_data.err == ERR_NONE) n_pc = r_pc + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_pc <= 16'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_pc <= n_pc;
            if (load) r_valid <= 1'b1;
            else if (i_pop) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_q_data.bytes[r_idx];
            r_addr <= r_pc;
            r_last <= last;
            r_err  <= i_q_data.err;
        end
    end

    assign o_empty        = !r_valid;
    assign o_code_byte    = r_byte;
    assign o_byte_address = r_addr;
    assign o_last_of_run  = r_last;
    assign o_error_code   = r_err;

endmodule
`default_nettype wire

/* sv/z80_instruction_encoder_top.sv */
`default_nettype none
// Channel   Handshake            Payload
// input     i_push / o_full      command, operand_form, registers, immediate
// result    o_empty / i_pop      code_byte, byte_address, last_of_run, error_code
//
// The front classifies a word in the cycle it is pushed and writes its whole
// byte list into a two-entry queue; the back emits one byte a cycle from it
// while the output is free or popped. An instruction has 1 to 8 bytes; an error
// word emits one. No-instruction words are dropped at the front.
// Synchronous active-low reset empties queue and output, clears the counter.
// A stalled pop holds the output register; pushes continue until the queue fills.
module z80_instruction_encoder_top
    import z80ie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [5:0]  i_command,
    input  wire logic [3:0]  i_operand_form,
    input  wire logic [4:0]  i_first_register,
    input  wire logic [4:0]  i_second_register,
    input  wire logic [16:0] i_immediate_value,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [7:0]       o_code_byte,
    output logic [15:0]      o_byte_address,
    output logic             o_last_of_run,
    output logic [2:0]       o_error_code
);

    t_instr front_instr;
    t_instr q_data;
    logic   q_full, q_empty, q_rd, q_wr;

    z80ie_front u_front (
        .i_command         (i_command),
        .i_operand_form    (i_operand_form),
        .i_first_register  (i_first_register),
        .i_second_register (i_second_register),
        .i_immediate_value (i_immediate_value),
        .o_instr           (front_instr)
    );

    // words without an instruction make no entry
    assign q_wr   = i_push && !q_full && (i_command != CmdNone);
    assign o_full = q_full;

    z80ie_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (front_instr),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    z80ie_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_data       (q_data),
        .o_q_rd         (q_rd),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_code_byte    (o_code_byte),
        .o_byte_address (o_byte_address),
        .o_last_of_run  (o_last_of_run),
        .o_error_code   (o_error_code)
    );

endmodule
`default_nettype wire
